@@ sv/gch_pkg.sv @@
// Shared types and constants for the guide confidence block.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package gch_pkg;

    localparam int SCORE_BITS   = 16;
    localparam int COUNT_BITS   = 16;
    localparam int FIELD_BITS   = 16;
    localparam int REG_COUNT    = 8;
    localparam int REG_IDX_BITS = $clog2(REG_COUNT);
    localparam int MUL_BITS     = 2 * SCORE_BITS;
    localparam int PROD_BITS    = 4 * SCORE_BITS;
    localparam int BIT_IDX_BITS = $clog2(SCORE_BITS);
    localparam int CMP_BITS     = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

    typedef logic [FIELD_BITS-1:0] t_field;
    typedef logic [SCORE_BITS-1:0] t_score;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_ENTER     = 3'd0,
        REG_EXIT      = 3'd1,
        REG_GOOD_NEED = 3'd2,
        REG_BAD_NEED  = 3'd3,
        REG_VALID_FL  = 3'd4,
        REG_TEMP_FL   = 3'd5,
        REG_DEPTH_FL  = 3'd6,
        REG_MAG_FL    = 3'd7
    } t_reg_idx;

    localparam t_field CFG_RESET [REG_COUNT] = '{
        16'd47186, 16'd29491, 16'd3, 16'd3,
        16'd16384, 16'd9830, 16'd13107, 16'd13107
    };

    typedef struct packed {
        t_field valid_fl;
        t_field temp_fl;
        t_field depth_fl;
        t_field mag_fl;
    } t_floors;

    typedef struct packed {
        t_field enter;
        t_field exit_eff;
        t_field gneed;
        t_field bneed;
    } t_back_cfg;

    typedef struct packed {
        logic   clear;
        logic   gated;
        t_score s0;
        t_score s1;
        t_score s2;
        t_score s3;
    } t_job;

    typedef struct packed {
        logic   reliable;
        t_field confidence;
        t_field good;
        t_field bad;
    } t_result;

endpackage

`default_nettype wire

@@ sv/gch_front.sv @@
// Front end: takes frames, classifies clear / gated / compute, queues jobs.
// Depends on gch_pkg.
`default_nettype none

module gch_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       push,
    output logic                      full,
    input  wire                       i_guide_present,
    input  wire                       i_scene_cut,
    input  wire                       i_history_clear,
    input  wire  [15:0]               i_valid_ratio,
    input  wire  [15:0]               i_temporal_score,
    input  wire  [15:0]               i_depth_score,
    input  wire  [15:0]               i_magnitude_score,
    input  wire  gch_pkg::t_floors    i_floors,
    output gch_pkg::t_job             o_job,
    output logic                      o_job_valid,
    input  wire                       i_job_take
);
    import gch_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    t_job                w_job;
    logic                w_wr;
    logic                w_rd;

    always_comb begin
        w_job.s0    = i_valid_ratio[SCORE_BITS-1:0];
        w_job.s1    = i_temporal_score[SCORE_BITS-1:0];
        w_job.s2    = i_depth_score[SCORE_BITS-1:0];
        w_job.s3    = i_magnitude_score[SCORE_BITS-1:0];
        w_job.clear = i_scene_cut | i_history_clear | ~i_guide_present;
        w_job.gated = (FIELD_BITS'(w_job.s0) < i_floors.valid_fl) |
                      (FIELD_BITS'(w_job.s1) < i_floors.temp_fl)  |
                      (FIELD_BITS'(w_job.s2) < i_floors.depth_fl) |
                      (FIELD_BITS'(w_job.s3) < i_floors.mag_fl);
    end

    assign full        = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];
    assign w_wr        = push & ~full;
    assign w_rd        = i_job_take & o_job_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/gch_back.sv @@
// Back end: product and fourth root on a shared multiplier, hysteresis counters,
// result register. Depends on gch_pkg.
`default_nettype none

module gch_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  gch_pkg::t_job             i_job,
    input  wire                       i_job_valid,
    output logic                      o_job_take,
    input  gch_pkg::t_back_cfg        i_cfg,
    output logic                      empty,
    input  wire                       pop,
    output gch_pkg::t_result          o_result
);
    import gch_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL_A = 7'b0000010,
        ST_MUL_B = 7'b0000100,
        ST_MUL_P = 7'b0001000,
        ST_SQ    = 7'b0010000,
        ST_P4    = 7'b0100000,
        ST_UPD   = 7'b1000000
    } t_state;

    t_state                  r_state;
    t_job                    r_job;
    logic [MUL_BITS-1:0]     r_pa;
    logic [MUL_BITS-1:0]     r_pb;
    logic [PROD_BITS-1:0]    r_prod;
    logic [MUL_BITS-1:0]     r_sq;
    t_score                  r_conf;
    logic [BIT_IDX_BITS-1:0] r_bit;
    logic                    r_rel;
    t_count                  r_good;
    t_count                  r_bad;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [MUL_BITS-1:0]     w_ma;
    logic [MUL_BITS-1:0]     w_mb;
    logic [PROD_BITS-1:0]    w_mul;
    t_score                  w_trial;
    logic                    w_slot_free;
    logic                    w_good;
    logic                    w_bad;
    t_count                  n_good;
    t_count                  n_bad;
    logic                    n_rel;

    assign w_trial = r_conf | (t_score'(1) << r_bit);

    // one shared multiplier, operands picked by the sequencer
    always_comb begin
        case (r_state)
            ST_MUL_A: begin
                w_ma = MUL_BITS'(r_job.s0);
                w_mb = MUL_BITS'(r_job.s1);
            end
            ST_MUL_B: begin
                w_ma = MUL_BITS'(r_job.s2);
                w_mb = MUL_BITS'(r_job.s3);
            end
            ST_MUL_P: begin
                w_ma = r_pa;
                w_mb = r_pb;
            end
            ST_SQ: begin
                w_ma = MUL_BITS'(w_trial);
                w_mb = MUL_BITS'(w_trial);
            end
            ST_P4: begin
                w_ma = r_sq;
                w_mb = r_sq;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul = {{MUL_BITS{1'b0}}, w_ma} * {{MUL_BITS{1'b0}}, w_mb};

    assign o_job_take  = (r_state == ST_IDLE) & i_job_valid;
    assign w_slot_free = ~r_out_valid | pop;
    assign empty       = ~r_out_valid;
    assign o_result    = r_out;

    // hysteresis update; gated jobs arrive with r_conf at zero
    always_comb begin
        w_good = ~r_job.gated & (FIELD_BITS'(r_conf) >= i_cfg.enter);
        w_bad  = r_job.gated | (FIELD_BITS'(r_conf) < i_cfg.exit_eff);
        n_good = r_good;
        n_bad  = r_bad;
        if (w_good) begin
            if (r_good != '1) begin
                n_good = r_good + 1'b1;
            end
            n_bad = '0;
        end else if (w_bad) begin
            if (r_bad != '1) begin
                n_bad = r_bad + 1'b1;
            end
            n_good = '0;
        end else begin
            if (r_good != '0) begin
                n_good = r_good - 1'b1;
            end
            if (r_bad != '0) begin
                n_bad = r_bad - 1'b1;
            end
        end
        n_rel = r_rel;
        if (!n_rel && (CMP_BITS'(n_good) >= CMP_BITS'(i_cfg.gneed))) begin
            n_rel = 1'b1;
        end
        if (n_rel && (CMP_BITS'(n_bad) >= CMP_BITS'(i_cfg.bneed))) begin
            n_rel = 1'b0;
        end
        if (r_job.clear) begin
            n_good = '0;
            n_bad  = '0;
            n_rel  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_job  <= i_job;
                    r_conf <= '0;
                end
            end
            ST_MUL_A: r_pa <= w_mul[MUL_BITS-1:0];
            ST_MUL_B: r_pb <= w_mul[MUL_BITS-1:0];
            ST_MUL_P: begin
                r_prod <= w_mul;
                r_bit  <= BIT_IDX_BITS'(SCORE_BITS - 1);
            end
            ST_SQ: r_sq <= w_mul[MUL_BITS-1:0];
            ST_P4: begin
                if (w_mul <= r_prod) begin
                    r_conf <= w_trial;
                end
                r_bit <= r_bit - 1'b1;
            end
            ST_UPD: begin
                if (w_slot_free) begin
                    r_out.reliable   <= n_rel;
                    r_out.confidence <= r_job.clear ? '0 : FIELD_BITS'(r_conf);
                    r_out.good       <= FIELD_BITS'(n_good);
                    r_out.bad        <= FIELD_BITS'(n_bad);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rel       <= 1'b0;
            r_good      <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= (i_job.clear || i_job.gated) ? ST_UPD : ST_MUL_A;
                    end
                end
                ST_MUL_A: r_state <= ST_MUL_B;
                ST_MUL_B: r_state <= ST_MUL_P;
                ST_MUL_P: r_state <= ST_SQ;
                ST_SQ:    r_state <= ST_P4;
                ST_P4: begin
                    r_state <= (r_bit == '0) ? ST_UPD : ST_SQ;
                end
                ST_UPD: begin
                    if (w_slot_free) begin
                        r_rel   <= n_rel;
                        r_good  <= n_good;
                        r_bad   <= n_bad;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // a new result may land in the same cycle the old one is popped
            if ((r_state == ST_UPD) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/guide_confidence_hysteresis.sv @@
// Top level: configuration registers, front classifier/queue and back end.
// Depends on gch_pkg, gch_front, gch_back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | push / full         | i_guide_present, i_scene_cut, i_history_clear,
//           |                     | i_valid_ratio, i_temporal_score, i_depth_score,
//           |                     | i_magnitude_score
//  result   | empty / pop         | o_is_reliable, o_confidence, o_good_count,
//           |                     | o_bad_count
//  config   | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// A computed frame goes through three products on the single 32x32 multiplier,
// then two multiplier passes per root bit over 16 bits, then the counter update.
// A clearing or gated frame goes straight to the counter update.
// The front queue holds two frames, so input keeps flowing while the back works
// and a finished result waits on the output register.
// Synchronous active-low reset empties both queues and clears the counters.
`default_nettype none

module guide_confidence_hysteresis (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 push,
    output logic                                full,
    input  wire                                 i_guide_present,
    input  wire                                 i_scene_cut,
    input  wire                                 i_history_clear,
    input  wire  [15:0]                         i_valid_ratio,
    input  wire  [15:0]                         i_temporal_score,
    input  wire  [15:0]                         i_depth_score,
    input  wire  [15:0]                         i_magnitude_score,
    output logic                                empty,
    input  wire                                 pop,
    output logic                                o_is_reliable,
    output logic [15:0]                         o_confidence,
    output logic [15:0]                         o_good_count,
    output logic [15:0]                         o_bad_count,
    input  wire                                 i_cfg_we,
    input  wire  [gch_pkg::REG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire  [gch_pkg::FIELD_BITS-1:0]      i_cfg_data
);
    import gch_pkg::*;

    t_field    r_cfg [REG_COUNT];
    t_floors   w_floors;
    t_back_cfg w_bcfg;
    t_job      w_job;
    logic      w_job_valid;
    logic      w_job_take;
    t_result   w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        w_floors.valid_fl = r_cfg[REG_VALID_FL];
        w_floors.temp_fl  = r_cfg[REG_TEMP_FL];
        w_floors.depth_fl = r_cfg[REG_DEPTH_FL];
        w_floors.mag_fl   = r_cfg[REG_MAG_FL];
        w_bcfg.enter      = r_cfg[REG_ENTER];
        // exit is capped at enter; zero requirements act as one
        w_bcfg.exit_eff   = (r_cfg[REG_EXIT] < r_cfg[REG_ENTER]) ?
                            r_cfg[REG_EXIT] : r_cfg[REG_ENTER];
        w_bcfg.gneed      = (r_cfg[REG_GOOD_NEED] == '0) ? t_field'(1) : r_cfg[REG_GOOD_NEED];
        w_bcfg.bneed      = (r_cfg[REG_BAD_NEED] == '0) ? t_field'(1) : r_cfg[REG_BAD_NEED];
    end

    gch_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_guide_present   (i_guide_present),
        .i_scene_cut       (i_scene_cut),
        .i_history_clear   (i_history_clear),
        .i_valid_ratio     (i_valid_ratio),
        .i_temporal_score  (i_temporal_score),
        .i_depth_score     (i_depth_score),
        .i_magnitude_score (i_magnitude_score),
        .i_floors          (w_floors),
        .o_job             (w_job),
        .o_job_valid       (w_job_valid),
        .i_job_take        (w_job_take)
    );

    gch_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_take  (w_job_take),
        .i_cfg       (w_bcfg),
        .empty       (empty),
        .pop         (pop),
        .o_result    (w_result)
    );

    assign o_is_reliable = w_result.reliable;
    assign o_confidence  = w_result.confidence;
    assign o_good_count  = w_result.good;
    assign o_bad_count   = w_result.bad;

endmodule

`default_nettype wire

@@ sv/gch_checker.sv @@
// Port-level checks for guide_confidence_hysteresis, attached by bind.
// Depends on gch_pkg widths only through the top level's ports.
`default_nettype none

module gch_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        full,
    input  wire        empty,
    input  wire        pop,
    input  wire        o_is_reliable,
    input  wire [15:0] o_confidence,
    input  wire [15:0] o_good_count,
    input  wire [15:0] o_bad_count
);

    // reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a good frame clears the bad run and vice versa; decay keeps one at zero
    a_runs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_good_count == 16'd0 || o_bad_count == 16'd0))
        else $error("good and bad counts both nonzero");

    // an unclaimed result stays put
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_confidence) &&
                              $stable(o_good_count) && $stable(o_bad_count) &&
                              $stable(o_is_reliable)))
        else $error("waiting result changed");

endmodule

bind guide_confidence_hysteresis gch_checker u_gch_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_is_reliable (o_is_reliable),
    .o_confidence  (o_confidence),
    .o_good_count  (o_good_count),
    .o_bad_count   (o_bad_count)
);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for guide_confidence_hysteresis: queue-style input and result ports.
// A scoreboard class predicts each result (fourth root, gating, hysteresis counters).
// Depends on gch_pkg and guide_confidence_hysteresis.

module testbench;
    import gch_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_FRAMES   = 175;

    typedef struct packed {
        logic   guide_present;
        logic   scene_cut;
        logic   history_clear;
        t_score valid_ratio;
        t_score temporal_score;
        t_score depth_score;
        t_score magnitude_score;
    } t_scene_frame;

    typedef t_field t_cfg_set [REG_COUNT];

    class conf_scoreboard;
        t_field  regs [REG_COUNT];
        bit      reliable;
        t_count  good_run;
        t_count  bad_run;
        t_result pending [$];
        int      errors;

        function new();
            regs     = CFG_RESET;
            reliable = 1'b0;
            good_run = '0;
            bad_run  = '0;
            errors   = 0;
        endfunction

        function void set_reg(t_reg_idx idx, t_field value);
            regs[idx] = value;
        endfunction

        // Largest c with c^4 <= prod, one bit at a time from the top.
        function t_score root4(bit [63:0] prod);
            t_score    c;
            t_score    trial;
            bit [63:0] sq;
            c = '0;
            for (int b = SCORE_BITS - 1; b >= 0; b--) begin
                trial = c | (t_score'(1) << b);
                sq    = 64'(trial) * 64'(trial);
                if (sq * sq <= prod)
                    c = trial;
            end
            return c;
        endfunction

        function void note_frame(t_scene_frame f);
            t_field  enter_lvl;
            t_field  exit_lvl;
            t_field  gneed;
            t_field  bneed;
            t_score  conf;
            bit      gated;
            bit      good;
            bit      bad;
            t_result r;
            enter_lvl = regs[REG_ENTER];
            exit_lvl  = (regs[REG_EXIT] < enter_lvl) ? regs[REG_EXIT] : enter_lvl;
            gneed     = (regs[REG_GOOD_NEED] == '0) ? t_field'(1) : regs[REG_GOOD_NEED];
            bneed     = (regs[REG_BAD_NEED] == '0) ? t_field'(1) : regs[REG_BAD_NEED];
            conf      = '0;
            if (f.scene_cut || f.history_clear || !f.guide_present) begin
                reliable = 1'b0;
                good_run = '0;
                bad_run  = '0;
                pending.push_back('0);
                return;
            end
            gated = f.valid_ratio < regs[REG_VALID_FL] || f.temporal_score < regs[REG_TEMP_FL] ||
                    f.depth_score < regs[REG_DEPTH_FL] || f.magnitude_score < regs[REG_MAG_FL];
            if (!gated)
                conf = root4(64'(f.valid_ratio) * 64'(f.temporal_score) *
                             64'(f.depth_score) * 64'(f.magnitude_score));
            good = !gated && conf >= enter_lvl;
            bad  = gated || conf < exit_lvl;
            if (good) begin
                if (good_run != '1)
                    good_run++;
                bad_run = '0;
            end else if (bad) begin
                if (bad_run != '1)
                    bad_run++;
                good_run = '0;
            end else begin
                // dead band: both counters decay
                if (good_run != '0)
                    good_run--;
                if (bad_run != '0)
                    bad_run--;
            end
            if (!reliable && good_run >= gneed)
                reliable = 1'b1;
            if (reliable && bad_run >= bneed)
                reliable = 1'b0;
            r.reliable   = reliable;
            r.confidence = conf;
            r.good       = good_run;
            r.bad        = bad_run;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t mismatch %s: expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = pending.pop_front();
            compare_field("is_reliable", 32'(want.reliable), 32'(got.reliable));
            compare_field("confidence", 32'(want.confidence), 32'(got.confidence));
            compare_field("good_count", 32'(want.good), 32'(got.good));
            compare_field("bad_count", 32'(want.bad), 32'(got.bad));
        endfunction
    endclass

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         push       = 1'b0;
    logic         pop        = 1'b0;
    t_scene_frame in_frame   = '0;
    logic         i_cfg_we   = 1'b0;
    t_reg_idx     i_cfg_idx  = REG_ENTER;
    t_field       i_cfg_data = '0;
    wire          full;
    wire          empty;
    wire          o_is_reliable;
    wire [15:0]   o_confidence;
    wire [15:0]   o_good_count;
    wire [15:0]   o_bad_count;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;

    conf_scoreboard sb = new();

    guide_confidence_hysteresis uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_guide_present   (in_frame.guide_present),
        .i_scene_cut       (in_frame.scene_cut),
        .i_history_clear   (in_frame.history_clear),
        .i_valid_ratio     (in_frame.valid_ratio),
        .i_temporal_score  (in_frame.temporal_score),
        .i_depth_score     (in_frame.depth_score),
        .i_magnitude_score (in_frame.magnitude_score),
        .empty             (empty),
        .pop               (pop),
        .o_is_reliable     (o_is_reliable),
        .o_confidence      (o_confidence),
        .o_good_count      (o_good_count),
        .o_bad_count       (o_bad_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Transaction monitor and watchdog; values read here are the pre-edge ones.
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (push && !full)
                sb.note_frame(in_frame);
            if (pop && !empty) begin
                got.reliable   = o_is_reliable;
                got.confidence = o_confidence;
                got.good       = o_good_count;
                got.bad        = o_bad_count;
                sb.check_result(got);
            end
            if ((push && !full) || (pop && !empty) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog expired with %0d results outstanding",
                         $time, sb.pending.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic t_scene_frame make_frame(bit present, bit cut, bit clr,
                                                int unsigned a, int unsigned b,
                                                int unsigned c, int unsigned d);
        t_scene_frame f;
        f.guide_present   = present;
        f.scene_cut       = cut;
        f.history_clear   = clr;
        f.valid_ratio     = t_score'(a);
        f.temporal_score  = t_score'(b);
        f.depth_score     = t_score'(c);
        f.magnitude_score = t_score'(d);
        return f;
    endfunction

    function automatic t_score score_near(int level);
        int v;
        case ($urandom_range(0, 15))
            0: begin
                v = $urandom_range(0, 65535);
            end
            1: begin
                v = 0;
            end
            2: begin
                v = 65535;
            end
            default: begin
                v = level + $urandom_range(0, 3000) - 1500;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
            end
        endcase
        return t_score'(v);
    endfunction

    // Mostly well-formed frames around a level; some carry random control bits.
    function automatic t_scene_frame random_frame(int level);
        t_scene_frame f;
        if ($urandom_range(0, 99) < 88) begin
            f.guide_present = 1'b1;
            f.scene_cut     = 1'b0;
            f.history_clear = 1'b0;
        end else begin
            f.guide_present = 1'($urandom_range(0, 1));
            f.scene_cut     = 1'($urandom_range(0, 1));
            f.history_clear = 1'($urandom_range(0, 1));
        end
        f.valid_ratio     = score_near(level);
        f.temporal_score  = score_near(level);
        f.depth_score     = score_near(level);
        f.magnitude_score = score_near(level);
        return f;
    endfunction

    function automatic t_cfg_set random_config();
        t_cfg_set c;
        c[REG_ENTER]     = t_field'($urandom_range(16384, 65535));
        c[REG_EXIT]      = t_field'($urandom_range(0, 65535));
        c[REG_GOOD_NEED] = t_field'($urandom_range(0, 5));
        c[REG_BAD_NEED]  = t_field'($urandom_range(0, 5));
        c[REG_VALID_FL]  = t_field'($urandom_range(0, 20000));
        c[REG_TEMP_FL]   = t_field'($urandom_range(0, 20000));
        c[REG_DEPTH_FL]  = t_field'($urandom_range(0, 20000));
        c[REG_MAG_FL]    = t_field'($urandom_range(0, 20000));
        return c;
    endfunction

    // Leaves push high; the caller lowers it once the stream is done.
    task automatic send_frame(t_scene_frame f);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        in_frame <= f;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    task automatic settle();
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic load_config(t_cfg_set vals);
        for (int i = 0; i < REG_COUNT; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(i);
            i_cfg_data <= vals[i];
            sb.set_reg(t_reg_idx'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        int sent;
        int burst;
        int level;
        sent = 0;
        while (sent < count) begin
            // bursts at one level so the counters build up and the flag toggles
            burst = $urandom_range(1, 8);
            level = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 65535);
            repeat (burst) begin
                send_frame(random_frame(level));
                sent++;
            end
        end
        push <= 1'b0;
    endtask

    task automatic run_directed();
        send_frame(make_frame(1, 0, 0, 65535, 65535, 65535, 65535));
        send_frame(make_frame(1, 0, 0, 65535, 65535, 65535, 65535));
        send_frame(make_frame(1, 0, 0, 65535, 65535, 65535, 65535));
        // scores exactly on their floors pass the gate
        send_frame(make_frame(1, 0, 0, 16384, 9830, 13107, 13107));
        send_frame(make_frame(1, 0, 0, 16383, 65535, 65535, 65535));
        send_frame(make_frame(1, 0, 0, 65535, 9829, 65535, 65535));
        send_frame(make_frame(1, 0, 0, 65535, 65535, 13106, 65535));
        send_frame(make_frame(1, 0, 0, 65535, 65535, 65535, 13106));
        // confidence equal to enter counts good, equal to exit sits in the dead band
        send_frame(make_frame(1, 0, 0, 47186, 47186, 47186, 47186));
        send_frame(make_frame(1, 0, 0, 29491, 29491, 29491, 29491));
        send_frame(make_frame(1, 0, 0, 39321, 39321, 39321, 39321));
        send_frame(make_frame(1, 1, 0, 65535, 65535, 65535, 65535));
        send_frame(make_frame(1, 0, 1, 65535, 65535, 65535, 65535));
        send_frame(make_frame(0, 0, 0, 65535, 65535, 65535, 65535));
        send_frame(make_frame(1, 1, 1, 0, 0, 0, 0));
        send_frame(make_frame(0, 1, 1, 65535, 65535, 65535, 65535));
        send_frame(make_frame(1, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(1, 0, 0, 65535, 65535, 65535, 65535));
        send_frame(make_frame(1, 0, 0, 65535, 65535, 65535, 65535));
        send_frame(make_frame(1, 0, 0, 47185, 47185, 47185, 47185));
        send_frame(make_frame(1, 0, 0, 29490, 29490, 29490, 29490));
        send_frame(make_frame(1, 0, 0, 65535, 16384, 65535, 40000));
        push <= 1'b0;
    endtask

    initial begin
        t_cfg_set cfg;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    cfg = CFG_RESET;
                end
                1: begin
                    // zero requirements act as one; zero floors never gate
                    foreach (cfg[i])
                        cfg[i] = '0;
                end
                2: begin
                    foreach (cfg[i])
                        cfg[i] = '1;
                end
                default: begin
                    cfg = random_config();
                end
            endcase
            settle();
            case (ph % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 51;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 51;
                end
                default: begin
                    tx_idle_pct  = 28;
                    rx_stall_pct = 28;
                end
            endcase
            load_config(cfg);
            run_random(PHASE_FRAMES);
        end

        settle();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/gch_pkg.sv
sv/gch_front.sv
sv/gch_back.sv
sv/guide_confidence_hysteresis.sv
sv/gch_checker.sv
bench/testbench.sv
